// ===== rtl/wcn_pkg.sv =====
// Shared widths, limits and types of the weighted component normalizer.
package wcn_pkg;

    localparam int MAX_COMPONENTS = 16;
    localparam int IDX_W          = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);
    localparam int Q_W            = 32;
    localparam int PROD_W         = 2 * Q_W;
    localparam int FRAC_W         = 16;
    localparam int SUM_W          = 36;
    localparam int REM_W          = SUM_W + 1;
    localparam int SHARE_W        = FRAC_W + 1;
    localparam int COMP_IDX_W     = 6;
    localparam int QCNT_W         = $clog2(SHARE_W);

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [Q_W-1:0]     Q_MAX     = {Q_W{1'b1}};
    localparam logic [SHARE_W-1:0] SHARE_ONE = SHARE_W'(1) << FRAC_W;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== rtl/weighted_component_normalizer_unit.sv =====
// Weighted component normalizer: sequencer, numerator store and group sum.
//
// Usage: drive one component word (weight_value, scale_value, loading_value,
// last_component) with start while busy is low; it is taken at that edge.
// Each word passes two 32x32 multiplies around a saturating add, then store
// and accumulate, before the next start is taken. The numerator goes into a
// 16-entry synchronous store and the saturating group sum is updated.
// When a word carries last_component, or the store is full, the block emits
// one result per stored component in arrival order on share_value,
// component_index, last_result and zero_sum, each marked by result_valid for
// exactly one cycle. Each share passes the store read, the divider start, the
// 17 bit steps of the serial divider, done and emit; on a zero group sum
// the divider is skipped and each share reads 0 with zero_sum set.
// busy stays high until the final share has been shown.
// The receiver cannot stall: results are never held back.
// lambda_offset is written through cfg_valid/cfg_ready (always ready) and
// must only change while busy is low. Reset clears the sum, the component
// count, lambda_offset and the sequencer; the store itself is not cleared.
module weighted_component_normalizer_unit
    import wcn_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [Q_W-1:0]        weight_value,
    input  logic [Q_W-1:0]        scale_value,
    input  logic [Q_W-1:0]        loading_value,
    input  logic                  last_component,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [Q_W-1:0]        lambda_offset,
    output logic                  result_valid,
    output logic [SHARE_W-1:0]    share_value,
    output logic [COMP_IDX_W-1:0] component_index,
    output logic                  last_result,
    output logic                  zero_sum
);

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL1 = 9'b000000010,
        ST_ADD  = 9'b000000100,
        ST_MUL2 = 9'b000001000,
        ST_ACC  = 9'b000010000,
        ST_READ = 9'b000100000,
        ST_DIVS = 9'b001000000,
        ST_DIVW = 9'b010000000,
        ST_EMIT = 9'b100000000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    logic [Q_W-1:0]       lambda_reg;
    logic [Q_W-1:0]       weight_reg;
    logic [Q_W-1:0]       scale_reg;
    logic [Q_W-1:0]       loading_reg;
    logic                 last_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [Q_W-1:0]       opa_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     last_idx_reg;
    logic [IDX_W-1:0]     emit_idx_reg;
    logic [SHARE_W-1:0]   share_reg;
    logic [Q_W-1:0]       rd_data_reg;
    logic [Q_W-1:0]       num_mem [MAX_COMPONENTS];
    logic [Q_W-1:0]       prod_sat;
    logic [Q_W:0]         add_wide;
    logic [SUM_W:0]       sum_wide;
    logic                 group_close;
    logic                 sum_zero;
    logic                 div_start;
    div_status_t          div_status;
    logic [SHARE_W-1:0]   div_quot;

    // Saturate the Q16.16 product and the lambda add, widen the sum
    always_comb
    begin
        prod_sat    = (|prod_reg[PROD_W-1:Q_W+FRAC_W]) ? Q_MAX
                                                       : prod_reg[Q_W+FRAC_W-1:FRAC_W];
        add_wide    = {1'b0, prod_sat} + {1'b0, lambda_reg};
        sum_wide    = {1'b0, sum_reg} + (SUM_W + 1)'(prod_sat);
        group_close = last_reg || (count_reg == CNT_W'(MAX_COMPONENTS - 1));
        sum_zero    = (sum_reg == '0);
        div_start   = (state_reg == ST_DIVS) && !sum_zero;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ST_MUL1;
            ST_MUL1: state_next = ST_ADD;
            ST_ADD:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_ACC;
            ST_ACC:  state_next = group_close ? ST_READ : ST_IDLE;
            ST_READ: state_next = ST_DIVS;
            ST_DIVS: state_next = sum_zero ? ST_EMIT : ST_DIVW;
            ST_DIVW: if (div_status.done) state_next = ST_EMIT;
            ST_EMIT: state_next = (emit_idx_reg == last_idx_reg) ? ST_IDLE : ST_READ;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers: state, config, sum, count, emit pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            lambda_reg   <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            emit_idx_reg <= '0;
            last_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                lambda_reg <= lambda_offset;
            end
            case (state_reg)
                ST_ACC:
                begin
                    sum_reg      <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    count_reg    <= count_reg + 1'b1;
                    last_idx_reg <= count_reg[IDX_W-1:0];
                    emit_idx_reg <= '0;
                end
                ST_EMIT:
                begin
                    if (emit_idx_reg == last_idx_reg)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                    end
                    else
                    begin
                        emit_idx_reg <= emit_idx_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath: latch the word, multiply, add lambda, capture the share
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    weight_reg  <= weight_value;
                    scale_reg   <= scale_value;
                    loading_reg <= loading_value;
                    last_reg    <= last_component;
                end
            end
            ST_MUL1: prod_reg <= weight_reg * scale_reg;
            ST_ADD:  opa_reg  <= add_wide[Q_W] ? Q_MAX : add_wide[Q_W-1:0];
            ST_MUL2: prod_reg <= opa_reg * loading_reg;
            ST_DIVS: if (sum_zero) share_reg <= '0;
            ST_DIVW: if (div_status.done) share_reg <= div_quot;
            default:
            begin
            end
        endcase
    end

    // Numerator store: write on accumulate, read at the emit pointer
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ACC)
        begin
            num_mem[count_reg[IDX_W-1:0]] <= prod_sat;
        end
        rd_data_reg <= num_mem[emit_idx_reg];
    end

    wcn_divider u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .div_start  (div_start),
        .div_num    (rd_data_reg),
        .div_den    (sum_reg),
        .div_status (div_status),
        .div_quot   (div_quot)
    );

    // Ports
    assign busy            = (state_reg != ST_IDLE);
    assign cfg_ready       = 1'b1;
    assign result_valid    = (state_reg == ST_EMIT);
    assign share_value     = share_reg;
    assign component_index = COMP_IDX_W'(emit_idx_reg);
    assign last_result     = (emit_idx_reg == last_idx_reg);
    assign zero_sum        = sum_zero;

    // A result only leaves while the block reports busy
    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result shown while idle");

    // Strobe lasts one cycle
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held");

    // Zero-sum groups force the share to zero
    a_zero_share: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_sum |-> share_value == '0)
        else $error("nonzero share on zero sum");

    // Share never exceeds one
    a_share_max: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> share_value <= SHARE_ONE)
        else $error("share above one");

endmodule

// ===== rtl/wcn_divider.sv =====
// Serial restoring divider: one quotient bit per cycle, numerator / sum as Q1.16.
module wcn_divider
    import wcn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               div_start,
    input  logic [Q_W-1:0]     div_num,
    input  logic [SUM_W-1:0]   div_den,
    output div_status_t        div_status,
    output logic [SHARE_W-1:0] div_quot
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [QCNT_W-1:0]    cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [SUM_W-1:0]     den_reg;
    logic [SHARE_W-1:0]   quot_reg;
    logic                 ge;
    logic [REM_W-1:0]     rem_sub;

    // Trial subtract of the divisor from the partial remainder
    always_comb
    begin
        ge      = (rem_reg >= {1'b0, den_reg});
        rem_sub = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
    end

    // Control: count down the quotient bits, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == '0);
            if (div_start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= QCNT_W'(SHARE_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: shift remainder, shift in one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            rem_reg  <= REM_W'(div_num);
            den_reg  <= div_den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= {rem_sub[REM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[SHARE_W-2:0], ge};
        end
    end

    assign div_status.busy = busy_reg;
    assign div_status.done = done_reg;
    assign div_quot        = quot_reg;

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the weighted component normalizer unit.
`timescale 1ns / 100ps

module tb_top;
    import wcn_pkg::*;

    // One component word as driven into the block
    typedef struct packed {
        logic [Q_W-1:0] weight;
        logic [Q_W-1:0] scale;
        logic [Q_W-1:0] loading;
        logic           last;
    } component_word_t;

    // One share word as the block should emit it
    typedef struct packed {
        logic [SHARE_W-1:0]    share;
        logic [COMP_IDX_W-1:0] comp_idx;
        logic                  last;
        logic                  zero;
    } share_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [Q_W-1:0]        weight_value = '0;
    logic [Q_W-1:0]        scale_value = '0;
    logic [Q_W-1:0]        loading_value = '0;
    logic                  last_component = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [Q_W-1:0]        lambda_offset = '0;
    logic                  result_valid;
    logic [SHARE_W-1:0]    share_value;
    logic [COMP_IDX_W-1:0] component_index;
    logic                  last_result;
    logic                  zero_sum;

    component_word_t component_queue[$];
    share_word_t     share_queue[$];
    int              mismatch_count = 0;
    int              sender_idle_pct = 0;

    // Predictor state: lambda, numerator store, group sum and fill level
    logic [Q_W-1:0]   lambda_now = '0;
    logic [Q_W-1:0]   numer_mem[MAX_COMPONENTS];
    logic [SUM_W-1:0] group_sum = '0;
    int               held = 0;

    weighted_component_normalizer_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .weight_value    (weight_value),
        .scale_value     (scale_value),
        .loading_value   (loading_value),
        .last_component  (last_component),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .lambda_offset   (lambda_offset),
        .result_valid    (result_valid),
        .share_value     (share_value),
        .component_index (component_index),
        .last_result     (last_result),
        .zero_sum        (zero_sum)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run limit, far above the slowest correct run
    initial
    begin
        #400000;
        $display("tb_top: errors");
        $finish;
    end

    // Fold one component into the group; emit the group's shares when it closes
    task automatic absorb_component(input component_word_t c);
        logic [2*Q_W-1:0] prod;
        logic [Q_W-1:0]   ws;
        logic [Q_W-1:0]   biased;
        logic [Q_W-1:0]   num;
        logic [Q_W:0]     s33;
        logic [SUM_W:0]   acc;
        logic [63:0]      quot;
        share_word_t      r;
        int               n;
        prod = ({32'b0, c.weight} * {32'b0, c.scale}) >> FRAC_W;
        ws = (prod[63:32] != 0) ? Q_MAX : prod[31:0];
        s33 = {1'b0, ws} + {1'b0, lambda_now};
        biased = s33[Q_W] ? Q_MAX : s33[Q_W-1:0];
        prod = ({32'b0, biased} * {32'b0, c.loading}) >> FRAC_W;
        num = (prod[63:32] != 0) ? Q_MAX : prod[31:0];

        if (held >= MAX_COMPONENTS)
            held = 0;
        numer_mem[held] = num;
        held++;
        acc = {1'b0, group_sum} + {5'b0, num};
        group_sum = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];

        if (!c.last && held < MAX_COMPONENTS)
            return;

        n = held;
        for (int k = 0; k < n; k++)
        begin
            quot = 0;
            if (group_sum != 0)
            begin
                quot = ({32'b0, numer_mem[k]} << FRAC_W) / {28'b0, group_sum};
                if (quot > 64'(SHARE_ONE))
                    quot = 64'(SHARE_ONE);
            end
            r.share    = quot[SHARE_W-1:0];
            r.comp_idx = COMP_IDX_W'(k);
            r.last     = (k == n - 1);
            r.zero     = (group_sum == 0);
            share_queue.push_back(r);
        end
        held = 0;
        group_sum = '0;
    endtask

    // Driver: hold the word while busy, else take the next one or idle
    component_word_t on_port;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
                absorb_component(on_port);
            if (!(start && busy))
            begin
                if (component_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    on_port = component_queue.pop_front();
                    weight_value   <= on_port.weight;
                    scale_value    <= on_port.scale;
                    loading_value  <= on_port.loading;
                    last_component <= on_port.last;
                    start          <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: match each shown share against the oldest expected one
    always @(posedge clk)
    begin : check_share
        share_word_t want;
        share_word_t got;
        if (rst_n && result_valid)
        begin
            got = '{share_value, component_index, last_result, zero_sum};
            if (share_queue.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected share %0d idx %0d last %0b zero %0b",
                             $realtime, got.share, got.comp_idx, got.last, got.zero);
                mismatch_count++;
            end
            else
            begin
                want = share_queue.pop_front();
                if (got.share != want.share || got.comp_idx != want.comp_idx ||
                    got.last != want.last || got.zero != want.zero)
                begin
                    if (mismatch_count < 10)
                        $display({"%0t: share mismatch exp %0d/%0d/%0b/%0b ",
                                  "got %0d/%0d/%0b/%0b (share/idx/last/zero)"},
                                 $realtime, want.share, want.comp_idx, want.last,
                                 want.zero, got.share, got.comp_idx, got.last, got.zero);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic void push_word(input logic [Q_W-1:0] w, input logic [Q_W-1:0] s,
                                      input logic [Q_W-1:0] l, input logic last);
        component_queue.push_back('{w, s, l, last});
    endfunction

    // Mix of zero, full-range, near-one and all-ones Q16.16 values
    function automatic logic [Q_W-1:0] rand_q();
        case ($urandom_range(5))
            0: return '0;
            1: return $urandom;
            2: return $urandom_range(32'h0002_0000);
            3: return Q_MAX;
            4: return $urandom_range(32'h0000_FFFF);
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    // Queue random groups until at least the given number of words is queued
    task automatic queue_groups(input int want);
        int count;
        int len;
        logic zero_load;
        count = 0;
        while (count < want)
        begin
            if ($urandom_range(99) < 85)
            begin
                // Well-formed group, sometimes with every loading zero
                len = $urandom_range(1, MAX_COMPONENTS);
                zero_load = ($urandom_range(9) == 0);
                for (int i = 0; i < len; i++)
                    push_word(rand_q(), rand_q(), zero_load ? '0 : rand_q(), i == len - 1);
            end
            else
            begin
                // Broken run: random length, scattered last marks
                len = $urandom_range(1, 24);
                for (int i = 0; i < len; i++)
                    push_word($urandom, $urandom, $urandom, $urandom_range(4) == 0);
            end
            count += len;
        end
    endtask

    // Wait until no word is pending, in flight or expected
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (component_queue.size() != 0 || start || busy || share_queue.size() != 0);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_lambda(input logic [Q_W-1:0] v);
        @(posedge clk);
        cfg_valid     <= 1'b1;
        lambda_offset <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        lambda_now = v;
    endtask

    int               idle_plan[6] = '{32, 32, 67, 67, 0, 0};
    logic [Q_W-1:0]   lambda_plan[6];

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with lambda at zero
        sender_idle_pct = 32;
        write_lambda('0);
        push_word(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
        push_word(Q_MAX, Q_MAX, Q_MAX, 1'b0);
        push_word(Q_MAX, Q_MAX, 32'h0000_8000, 1'b1);
        push_word(32'h0003_0000, 32'h0001_0000, '0, 1'b0);
        push_word(Q_MAX, Q_MAX, '0, 1'b1);
        // Fill the store without a last mark: the group closes on its own
        for (int i = 0; i < MAX_COMPONENTS; i++)
            push_word(Q_MAX, Q_MAX, Q_MAX, 1'b0);
        push_word('0, '0, '0, 1'b1);
        wait_quiet();

        // Random part over several lambda settings and idle rates
        lambda_plan = '{Q_MAX, $urandom, 32'h0001_0000, $urandom_range(32'hFFFF), '0, $urandom};
        for (int p = 0; p < 6; p++)
        begin
            write_lambda(lambda_plan[p]);
            sender_idle_pct = idle_plan[p];
            queue_groups(58);
            wait_quiet();
        end

        if (mismatch_count == 0 && share_queue.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wcn_pkg.sv
rtl/wcn_divider.sv
rtl/weighted_component_normalizer_unit.sv
bench/tb_top.sv
